FILE: rtl/core/dfv_pkg.sv
// ----------------------------------------------------------------------------
// dfv_pkg
// shared types, constants and the crc byte update for the frame validator
// ----------------------------------------------------------------------------
package dfv_pkg;

  // default width of the saturating byte counter
  localparam int unsigned COUNT_BITS_DEF = 12;

  // width used for byte positions and frame-length compares
  localparam int unsigned POS_W   = 18;
  localparam int unsigned LIMIT_W = 11;
  localparam int unsigned FLEN_W  = 11;

  // frame layout
  localparam logic [7:0]       HDR0     = 8'hA9;
  localparam logic [7:0]       HDR1     = 8'h9A;
  localparam logic [7:0]       END_MARK = 8'h16;
  localparam logic [POS_W-1:0] OFS_HDR0   = POS_W'(0);
  localparam logic [POS_W-1:0] OFS_HDR1   = POS_W'(1);
  localparam logic [POS_W-1:0] OFS_FUNC   = POS_W'(12);
  localparam logic [POS_W-1:0] OFS_CTRL   = POS_W'(13);
  localparam logic [POS_W-1:0] OFS_LEN_LO = POS_W'(14);
  localparam logic [POS_W-1:0] OFS_LEN_HI = POS_W'(15);
  localparam logic [POS_W-1:0] OFS_DATA   = POS_W'(16);
  localparam logic [POS_W-1:0] FRAME_OVH  = POS_W'(19);

  // crc-16/ccitt-false
  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_TOP  = 16'h8000;

  // configuration space
  localparam int unsigned       PADDR_W     = 3;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 11'd512;
  typedef enum logic [PADDR_W-3:0] {
    REG_MAX_LEN = 1'b0
  } reg_idx_t;

  typedef enum logic [2:0] {
    VERDICT_OK         = 3'd0,
    VERDICT_SHORT      = 3'd1,
    VERDICT_BAD_HDR    = 3'd2,
    VERDICT_TOO_LONG   = 3'd3,
    VERDICT_INCOMPLETE = 3'd4,
    VERDICT_BAD_END    = 3'd5,
    VERDICT_CRC_FAIL   = 3'd6
  } verdict_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       buffer_end;
  } rx_item_t;

  typedef struct packed {
    logic [15:0]       crc_received;
    logic [15:0]       crc_computed;
    logic [15:0]       payload_len;
    logic [7:0]        frame_ctrl;
    logic [7:0]        frame_func;
    logic [FLEN_W-1:0] frame_length;
    verdict_t          verdict;
  } result_t;

  // one byte through the crc, msb first
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if ((c & CRC_TOP) != 16'h0000) begin
        c = (c << 1) ^ CRC_POLY;
      end else begin
        c = c << 1;
      end
    end
    return c;
  endfunction

endpackage

FILE: rtl/core/dfv_cfg_regs.sv
// ----------------------------------------------------------------------------
// dfv_cfg_regs
// apb register file holding the data length limit
// ----------------------------------------------------------------------------
module dfv_cfg_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [dfv_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  output logic [dfv_pkg::LIMIT_W-1:0]  max_payload_len
);
  import dfv_pkg::*;

  logic     wr_en;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign idx    = reg_idx_t'(paddr[PADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      max_payload_len <= LIMIT_RESET;
    end else if (wr_en) begin
      unique case (idx)
        REG_MAX_LEN: max_payload_len <= pwdata[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_MAX_LEN: prdata = {{(32-LIMIT_W){1'b0}}, max_payload_len};
      default:     prdata = 32'h0000_0000;
    endcase
  end

endmodule

FILE: rtl/core/dfv_in_reg.sv
// ----------------------------------------------------------------------------
// dfv_in_reg
// input register stage between the byte stream and the frame checker
// ----------------------------------------------------------------------------
module dfv_in_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  dfv_pkg::rx_item_t in_item,
  output logic              out_valid,
  input  logic              out_ready,
  output dfv_pkg::rx_item_t out_item
);
  import dfv_pkg::*;

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_item <= in_item;
    end
  end

endmodule

FILE: rtl/core/dfv_frame_check.sv
// ----------------------------------------------------------------------------
// dfv_frame_check
// per-byte frame tracking, crc update, verdict and result register
// ----------------------------------------------------------------------------
module dfv_frame_check #(
  parameter int unsigned COUNT_BITS = dfv_pkg::COUNT_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  dfv_pkg::rx_item_t           in_item,
  input  logic [dfv_pkg::LIMIT_W-1:0] max_payload_len,
  output logic                        out_valid,
  input  logic                        out_ready,
  output dfv_pkg::result_t            result
);
  import dfv_pkg::*;

  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

  logic [COUNT_BITS-1:0] byte_count, byte_count_next, cnt_upd;
  logic [15:0]           crc_acc, crc_acc_next, crc_upd;
  logic                  header_ok, header_ok_next, hdr_upd;
  logic [15:0]           len_field, len_field_next, len_upd;
  logic [7:0]            func_byte, func_byte_next, func_upd;
  logic [7:0]            ctrl_byte, ctrl_byte_next, ctrl_upd;
  logic [15:0]           crc_field, crc_field_next, crcf_upd;
  logic [7:0]            end_byte, end_byte_next, end_upd;

  logic             take;
  logic [7:0]       b;
  logic [POS_W-1:0] pos, crc_at, rlen, flen;
  verdict_t         verdict;
  result_t          result_next;

  assign take = in_valid && in_ready;
  assign b    = in_item.rx_byte;
  // a last byte needs room in the result register
  assign in_ready = !(in_item.buffer_end && out_valid && !out_ready);

  always_comb begin
    cnt_upd  = byte_count;
    crc_upd  = crc_acc;
    hdr_upd  = header_ok;
    len_upd  = len_field;
    func_upd = func_byte;
    ctrl_upd = ctrl_byte;
    crcf_upd = crc_field;
    end_upd  = end_byte;
    pos      = {{(POS_W-COUNT_BITS){1'b0}}, byte_count};
    crc_at   = {{(POS_W-16){1'b0}}, len_field} + OFS_DATA;
    if (byte_count != CNT_MAX) begin
      if (pos == OFS_HDR0 && b != HDR0) hdr_upd = 1'b0;
      if (pos == OFS_HDR1 && b != HDR1) hdr_upd = 1'b0;
      if (pos == OFS_FUNC)   func_upd = b;
      if (pos == OFS_CTRL)   ctrl_upd = b;
      if (pos == OFS_LEN_LO) len_upd[7:0]  = b;
      if (pos == OFS_LEN_HI) len_upd[15:8] = b;
      if (pos < crc_at)      crc_upd = crc_byte(crc_acc, b);
      if (pos >= OFS_DATA) begin
        if (pos == crc_at)              crcf_upd[7:0]  = b;
        if (pos == crc_at + POS_W'(1))  crcf_upd[15:8] = b;
        if (pos == crc_at + POS_W'(2))  end_upd = b;
      end
      cnt_upd = byte_count + COUNT_BITS'(1);
    end
  end

  // verdict on the state including this byte
  always_comb begin
    rlen = {{(POS_W-COUNT_BITS){1'b0}}, cnt_upd};
    flen = {{(POS_W-16){1'b0}}, len_upd} + FRAME_OVH;
    if (rlen < OFS_DATA) begin
      verdict = VERDICT_SHORT;
    end else if (!hdr_upd) begin
      verdict = VERDICT_BAD_HDR;
    end else if (len_upd > {{(16-LIMIT_W){1'b0}}, max_payload_len}) begin
      verdict = VERDICT_TOO_LONG;
    end else if (flen > rlen) begin
      verdict = VERDICT_INCOMPLETE;
    end else if (end_upd != END_MARK) begin
      verdict = VERDICT_BAD_END;
    end else if (crc_upd != crcf_upd) begin
      verdict = VERDICT_CRC_FAIL;
    end else begin
      verdict = VERDICT_OK;
    end
    result_next.verdict      = verdict;
    result_next.frame_length = (verdict == VERDICT_OK) ? flen[FLEN_W-1:0] : '0;
    result_next.frame_func   = func_upd;
    result_next.frame_ctrl   = ctrl_upd;
    result_next.payload_len  = len_upd;
    result_next.crc_computed = crc_upd;
    result_next.crc_received = crcf_upd;
  end

  always_comb begin
    byte_count_next = byte_count;
    crc_acc_next    = crc_acc;
    header_ok_next  = header_ok;
    len_field_next  = len_field;
    func_byte_next  = func_byte;
    ctrl_byte_next  = ctrl_byte;
    crc_field_next  = crc_field;
    end_byte_next   = end_byte;
    if (take) begin
      if (in_item.buffer_end) begin
        byte_count_next = '0;
        crc_acc_next    = CRC_INIT;
        header_ok_next  = 1'b1;
        len_field_next  = '0;
        func_byte_next  = '0;
        ctrl_byte_next  = '0;
        crc_field_next  = '0;
        end_byte_next   = '0;
      end else begin
        byte_count_next = cnt_upd;
        crc_acc_next    = crc_upd;
        header_ok_next  = hdr_upd;
        len_field_next  = len_upd;
        func_byte_next  = func_upd;
        ctrl_byte_next  = ctrl_upd;
        crc_field_next  = crcf_upd;
        end_byte_next   = end_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
      crc_acc    <= CRC_INIT;
      header_ok  <= 1'b1;
      len_field  <= '0;
      func_byte  <= '0;
      ctrl_byte  <= '0;
      crc_field  <= '0;
      end_byte   <= '0;
    end else begin
      byte_count <= byte_count_next;
      crc_acc    <= crc_acc_next;
      header_ok  <= header_ok_next;
      len_field  <= len_field_next;
      func_byte  <= func_byte_next;
      ctrl_byte  <= ctrl_byte_next;
      crc_field  <= crc_field_next;
      end_byte   <= end_byte_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take && in_item.buffer_end) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && in_item.buffer_end) begin
      result <= result_next;
    end
  end

  a_clear_after_end: assert property (@(posedge clk) disable iff (rst)
    take && in_item.buffer_end |=> byte_count == '0 && crc_acc == CRC_INIT)
    else $error("frame state not cleared after last byte");

  a_count_monotonic: assert property (@(posedge clk) disable iff (rst)
    take && !in_item.buffer_end |=> byte_count >= $past(byte_count))
    else $error("byte count went backwards inside a frame");

  a_ok_length: assert property (@(posedge clk) disable iff (rst)
    out_valid && result.verdict == VERDICT_OK |->
      result.frame_length == FLEN_W'(result.payload_len + 16'd19) &&
      result.crc_computed == result.crc_received)
    else $error("ok verdict with inconsistent length or crc");

  a_fail_zero_length: assert property (@(posedge clk) disable iff (rst)
    out_valid && result.verdict != VERDICT_OK |-> result.frame_length == '0)
    else $error("failed verdict carries a frame length");

endmodule

FILE: rtl/core/downlink_frame_validator.sv
// ----------------------------------------------------------------------------
// downlink_frame_validator
// byte-stream checker for framed downlink packets with crc-16/ccitt-false
// ----------------------------------------------------------------------------
// a last byte is registered in the input register, then its result in the result register
// throughput: one byte per cycle; the per-byte crc update and all checks sit
//   between the input register and the result register
// a stalled result only holds back the next last byte, other bytes keep flowing
// reset: synchronous active-high rst empties both stages, clears the frame state
//   and loads the data length limit with 512
module downlink_frame_validator #(
  parameter int unsigned COUNT_BITS = dfv_pkg::COUNT_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  // byte stream in
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [7:0]                  s_tdata,   // rx_byte
  input  logic                        s_tlast,   // buffer_end
  // verdict stream out
  output logic                        m_tvalid,
  input  logic                        m_tready,
  // verdict[2:0], frame_length[13:3], frame_func[21:14], frame_ctrl[29:22],
  // payload_len[45:30], crc_computed[61:46], crc_received[77:62], zero fill
  output logic [79:0]                 m_tdata,
  // apb configuration
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [dfv_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import dfv_pkg::*;

  logic [LIMIT_W-1:0] max_payload_len;
  rx_item_t           s_item, q_item;
  logic               q_valid, q_ready;
  result_t            res;

  // data length limit register
  dfv_cfg_regs u_cfg (
    .clk             (clk),
    .rst             (rst),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .max_payload_len (max_payload_len)
  );

  assign s_item.rx_byte    = s_tdata;
  assign s_item.buffer_end = s_tlast;

  // input register: one byte transfer per cycle while the frame checker takes bytes
  dfv_in_reg u_in (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_item   (s_item),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_item  (q_item)
  );

  // frame tracking and verdict, result register on the output side
  dfv_frame_check #(
    .COUNT_BITS (COUNT_BITS)
  ) u_check (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (q_valid),
    .in_ready        (q_ready),
    .in_item         (q_item),
    .max_payload_len (max_payload_len),
    .out_valid       (m_tvalid),
    .out_ready       (m_tready),
    .result          (res)
  );

  // pack fields, first field in the low bits
  assign m_tdata = {2'b00, res.crc_received, res.crc_computed, res.payload_len,
                    res.frame_ctrl, res.frame_func, res.frame_length, res.verdict};

endmodule
